FILE: hdl/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
package bba_pkg;

  localparam int unsigned HdrW    = 9;
  localparam int unsigned SizeW   = 21;
  localparam int unsigned AddrW   = 20;
  localparam int unsigned StatW   = 2;
  localparam logic [HdrW-1:0] HdrReset = 9'd32;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_ZERO    = 2'd2,
    ST_BADFREE = 2'd3
  } status_e;

  localparam logic [1:0] PgNone  = 2'd0;
  localparam logic [1:0] PgFree  = 2'd1;
  localparam logic [1:0] PgAlloc = 2'd2;

  typedef struct packed {
    logic             kind;
    logic [SizeW-1:0] request_size;
    logic [AddrW-1:0] address;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [AddrW-1:0] address_res;
  } rsp_t;

endpackage

FILE: hdl/bba_ram.sv
// Generic single-port RAM with registered read data.
module bba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: hdl/buddy_block_allocator_core.sv
// Buddy block allocator core: sequencer over page-table and free-list memories.
//
// Usage: drive req_i and raise start while busy is low; the item is taken at
// that edge. One result appears on rsp_o for a single cycle with done_o high, in
// the same cycle that busy falls; the receiver cannot stall it. cfg_valid/cfg_ready
// write header_bytes (9 bits) and are taken only while the block is idle with
// start low or while it sweeps the page memory after reset.
//
// Each item is a walk of a small sequencer over one page memory (state, level,
// next, prev packed per page) with one access a cycle and registered reads.
// Busy time per item grows with the order steps and the levels scanned and with
// each split for an allocate, and with each merge for a free.
//
// After reset the block sweeps the page memory once, one entry a cycle,
// holding busy high; configuration writes are taken meanwhile. Reset sets
// header_bytes to 32 and puts the whole pool as one free block on the top list.
module buddy_block_allocator_core #(
  parameter int unsigned POOL_ORDER = 20,
  parameter int unsigned PAGE_ORDER = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  bba_pkg::req_t                req_i,
  output logic                         done_o,
  output bba_pkg::rsp_t                rsp_o,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bba_pkg::HdrW-1:0]     cfg_data_i
);
  localparam int unsigned TopLvl = POOL_ORDER - PAGE_ORDER;
  localparam int unsigned PgW    = (TopLvl < 1) ? 1 : TopLvl;
  localparam int unsigned LnkW   = TopLvl + 1;
  localparam int unsigned Npages = 1 << TopLvl;
  localparam int unsigned LvlW   = $clog2(TopLvl + 2);
  localparam int unsigned EntW   = 2 + LvlW + 2 * LnkW;
  localparam logic [LnkW-1:0] Nil = LnkW'(Npages);
  localparam int unsigned AW     = bba_pkg::AddrW;
  localparam int unsigned TW     = 32;

  typedef struct packed {
    logic [1:0]      st;
    logic [LvlW-1:0] lvl;
    logic [LnkW-1:0] nxt;
    logic [LnkW-1:0] prv;
  } ent_t;

  typedef enum logic [21:0] {
    S_INIT    = 22'h000001,
    S_IDLE    = 22'h000002,
    S_ORDER   = 22'h000004,
    S_SCAN    = 22'h000008,
    S_UL_RD   = 22'h000010,
    S_UL_WT   = 22'h000020,
    S_UL_PR   = 22'h000040,
    S_UL_NX   = 22'h000080,
    S_UL_NXW  = 22'h000100,
    S_UL_DONE = 22'h000200,
    S_PU_HD   = 22'h000400,
    S_PU_HDW  = 22'h000800,
    S_PU_WR   = 22'h001000,
    S_SPLIT   = 22'h002000,
    S_FIN     = 22'h004000,
    S_FR_RD   = 22'h008000,
    S_FR_WT   = 22'h010000,
    S_FR_CHK  = 22'h020000,
    S_BD_WT   = 22'h040000,
    S_BD_CHK  = 22'h080000,
    S_CLR_WT  = 22'h100000,
    S_RESP    = 22'h200000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic [bba_pkg::HdrW-1:0] hdr_q;
  logic [LnkW-1:0] head_q [TopLvl+1];
  logic [PgW-1:0]  cnt_q, cnt_d;
  logic [LvlW-1:0] want_q, want_d, cur_q, cur_d;
  logic [LnkW-1:0] pg_q, pg_d, tg_q, tg_d, pr_q, pr_d, nx_q, nx_d;
  logic            kind_q;
  logic [TW-1:0]   tot_q, tot_d;
  logic [bba_pkg::SizeW-1:0] size_q;
  logic [AW-1:0]   addr_q;
  logic [1:0]      stat_q, stat_d;
  logic [AW-1:0]   res_q, res_d;
  logic            done_q, done_d;

  logic            we;
  logic [PgW-1:0]  ma;
  ent_t            wd, rd;
  logic            hd_we;
  logic [LvlW-1:0] hd_lvl;
  logic [LnkW-1:0] hd_val;

  bba_ram #(.Width(EntW), .Depth(Npages)) u_pages (
    .clk_i(clk_i), .we_i(we), .addr_i(ma), .wdata_i(wd), .rdata_o(rd)
  );

  function automatic logic [PgW-1:0] pa(input logic [LnkW-1:0] p);
    return p[PgW-1:0];
  endfunction

  logic [LvlW-1:0] lvl_top;
  assign lvl_top = LvlW'(TopLvl);

  logic [LnkW-1:0] head_cur;
  assign head_cur = head_q[cur_q];

  logic [LnkW-1:0] bud_merge;
  assign bud_merge = pg_q ^ (LnkW'(1) << cur_q);

  logic [AW:0] off_w;
  assign off_w = {1'b0, addr_q} - {{(AW+1-bba_pkg::HdrW){1'b0}}, hdr_q};

  always_comb begin
    state_d = state_q; ret_d = ret_q; cnt_d = cnt_q;
    want_d = want_q; cur_d = cur_q; pg_d = pg_q; tg_d = tg_q;
    pr_d = pr_q; nx_d = nx_q; tot_d = tot_q;
    stat_d = stat_q; res_d = res_q; done_d = 1'b0;
    we = 1'b0; ma = pa(tg_q); wd = rd;
    hd_we = 1'b0; hd_lvl = cur_q; hd_val = Nil;
    case (state_q)
      S_INIT: begin
        we = 1'b1; ma = cnt_q;
        wd = '{st: bba_pkg::PgNone, lvl: '0, nxt: Nil, prv: Nil};
        if (cnt_q == '0) begin
          wd.st = bba_pkg::PgFree; wd.lvl = lvl_top;
        end
        cnt_d = cnt_q + PgW'(1);
        if (cnt_q == PgW'(Npages - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          state_d = S_ORDER; want_d = '0;
          tot_d = TW'((req_i.request_size + bba_pkg::SizeW'(3)) & ~bba_pkg::SizeW'(3))
                + TW'(req_i.request_size > bba_pkg::SizeW'(2097148) ? 32'h0020_0000 : 0)
                + TW'(hdr_q);
        end
      end
      S_ORDER: begin
        // one order compare per cycle
        if (kind_q) begin
          stat_d = bba_pkg::ST_OK; res_d = '0;
          if (off_w[AW] || off_w[PAGE_ORDER-1:0] != '0 ||
              (off_w[AW-1:0] >> PAGE_ORDER) >= AW'(Npages)) begin
            stat_d = bba_pkg::ST_BADFREE; state_d = S_RESP;
          end else begin
            pg_d = LnkW'(off_w[AW-1:0] >> PAGE_ORDER);
            tg_d = LnkW'(off_w[AW-1:0] >> PAGE_ORDER);
            state_d = S_FR_RD;
          end
        end else if (size_q == '0) begin
          stat_d = bba_pkg::ST_ZERO; res_d = '0; state_d = S_RESP;
        end else if (want_q > lvl_top) begin
          stat_d = bba_pkg::ST_OOM; res_d = '0; state_d = S_RESP;
        end else if ((TW'(1) << (TW'(want_q) + TW'(PAGE_ORDER))) >= tot_q) begin
          cur_d = want_q; state_d = S_SCAN;
        end else begin
          want_d = want_q + LvlW'(1);
        end
      end
      S_SCAN: begin
        if (cur_q > lvl_top) begin
          stat_d = bba_pkg::ST_OOM; res_d = '0; state_d = S_RESP;
        end else if (head_cur[TopLvl]) begin
          cur_d = cur_q + LvlW'(1);
        end else begin
          pg_d = head_cur; tg_d = head_cur; ret_d = S_SPLIT; state_d = S_UL_RD;
        end
      end
      // unlink tg from list cur
      S_UL_RD: begin ma = pa(tg_q); state_d = S_UL_WT; end
      S_UL_WT: begin
        pr_d = rd.prv; nx_d = rd.nxt;
        ma = pa(rd.prv);
        state_d = S_UL_PR;
        if (rd.prv[TopLvl]) begin
          hd_we = 1'b1; hd_val = rd.nxt; state_d = S_UL_NX;
        end
      end
      S_UL_PR: begin
        ma = pa(pr_q); we = 1'b1; wd = rd; wd.nxt = nx_q; state_d = S_UL_NX;
      end
      S_UL_NX: begin
        ma = pa(nx_q);
        state_d = nx_q[TopLvl] ? S_UL_DONE : S_UL_NXW;
      end
      S_UL_NXW: begin
        ma = pa(nx_q); we = 1'b1; wd = rd; wd.prv = pr_q; state_d = S_UL_DONE;
      end
      S_UL_DONE: begin
        ma = pa(tg_q); state_d = S_CLR_WT;
      end
      S_CLR_WT: begin
        ma = pa(tg_q); we = 1'b1; wd = rd; wd.nxt = Nil; wd.prv = Nil;
        state_d = ret_q;
      end
      // push tg at level cur with state free
      S_PU_HD: begin
        nx_d = head_cur; ma = pa(head_cur);
        state_d = head_cur[TopLvl] ? S_PU_WR : S_PU_HDW;
      end
      S_PU_HDW: begin
        ma = pa(nx_q); we = 1'b1; wd = rd; wd.prv = tg_q; state_d = S_PU_WR;
      end
      S_PU_WR: begin
        ma = pa(tg_q); we = 1'b1;
        wd = '{st: bba_pkg::PgFree, lvl: cur_q, nxt: nx_q, prv: Nil};
        hd_we = 1'b1; hd_val = tg_q;
        state_d = ret_q;
      end
      S_SPLIT: begin
        if (cur_q > want_q) begin
          cur_d = cur_q - LvlW'(1);
          tg_d = pg_q + (LnkW'(1) << (cur_q - LvlW'(1)));
          ret_d = S_SPLIT; state_d = S_PU_HD;
        end else begin
          ma = pa(pg_q); state_d = S_FIN;
        end
      end
      S_FIN: begin
        ma = pa(pg_q); we = 1'b1; wd = rd;
        wd.st = bba_pkg::PgAlloc; wd.lvl = want_q;
        stat_d = bba_pkg::ST_OK;
        res_d = AW'((TW'(pg_q) << PAGE_ORDER) + TW'(hdr_q));
        state_d = S_RESP;
      end
      S_FR_RD: begin ma = pa(pg_q); state_d = S_FR_WT; end
      S_FR_WT: state_d = S_FR_CHK;
      S_FR_CHK: begin
        ma = pa(pg_q);
        if (rd.st != bba_pkg::PgAlloc) begin
          stat_d = bba_pkg::ST_BADFREE; state_d = S_RESP;
        end else begin
          cur_d = (rd.lvl > lvl_top) ? lvl_top : rd.lvl;
          we = 1'b1; wd = rd; wd.st = bba_pkg::PgNone; wd.lvl = '0;
          state_d = S_BD_WT;
        end
      end
      S_BD_WT: begin
        if (cur_q >= lvl_top) begin
          tg_d = pg_q; ret_d = S_RESP; state_d = S_PU_HD;
        end else begin
          ma = pa(bud_merge); tg_d = bud_merge; state_d = S_BD_CHK;
        end
      end
      S_BD_CHK: begin
        ma = pa(tg_q);
        if (rd.st != bba_pkg::PgFree || rd.lvl != cur_q) begin
          tg_d = pg_q; ret_d = S_RESP; state_d = S_PU_HD;
        end else begin
          // clear buddy start now; its links survive for the unlink
          we = 1'b1; wd = rd; wd.st = bba_pkg::PgNone; wd.lvl = '0;
          if (tg_q < pg_q) pg_d = tg_q;
          ret_d = S_BD_WT; state_d = S_UL_RD;
        end
      end
      S_RESP: begin
        done_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_UL_DONE && ret_q == S_BD_WT) cur_d = cur_q + LvlW'(1);
  end

  assign busy      = (state_q != S_IDLE);
  // hold off a header write while an item is being taken
  assign cfg_ready = (state_q == S_IDLE && !start) || (state_q == S_INIT);
  assign done_o    = done_q;
  assign rsp_o     = '{status: stat_q, address_res: res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; ret_q <= S_IDLE; cnt_q <= '0; done_q <= 1'b0;
      hdr_q <= bba_pkg::HdrReset;
      for (int i = 0; i <= TopLvl; i++) head_q[i] <= (i == TopLvl) ? '0 : Nil;
    end else begin
      state_q <= state_d; ret_q <= ret_d; cnt_q <= cnt_d; done_q <= done_d;
      if (cfg_valid && cfg_ready) hdr_q <= cfg_data_i;
      if (hd_we) head_q[hd_lvl] <= hd_val;
    end
  end

  always_ff @(posedge clk_i) begin
    want_q <= want_d; cur_q <= cur_d; pg_q <= pg_d; tg_q <= tg_d;
    pr_q <= pr_d; nx_q <= nx_d; tot_q <= tot_d; stat_q <= stat_d; res_q <= res_d;
    if (state_q == S_IDLE && start) begin
      kind_q <= req_i.kind;
      size_q <= req_i.request_size;
      addr_q <= req_i.address;
    end
  end
endmodule

FILE: test/tb.sv
// Self-checking testbench for the buddy block allocator core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TopLvl = 8;
  localparam int unsigned NPages = 256;
  localparam logic [8:0]  NoPage = 9'd256;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  bba_pkg::req_t req_i = '0;
  logic done_o;
  bba_pkg::rsp_t rsp_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bba_pkg::HdrW-1:0] cfg_data_i = '0;

  buddy_block_allocator_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the allocator state
  logic [bba_pkg::HdrW-1:0] hdr_shadow;
  logic [8:0] free_head [0:TopLvl];
  logic [8:0] link_next [0:NPages-1];
  logic [8:0] link_prev [0:NPages-1];
  logic [1:0] pg_state  [0:NPages-1];
  logic [3:0] pg_level  [0:NPages-1];

  bba_pkg::rsp_t pending_rsp [$];
  int unsigned live_addr [$];
  int unsigned dead_addr [$];
  int unsigned n_errors = 0;
  int unsigned n_results = 0;
  int unsigned n_items = 0;
  int unsigned n_ok = 0;
  int unsigned n_oom = 0;
  int unsigned n_bad = 0;
  bit quiet = 1'b0;

  function automatic void shadow_reset();
    for (int i = 0; i <= TopLvl; i++) free_head[i] = NoPage;
    for (int i = 0; i < NPages; i++) begin
      link_next[i] = NoPage;
      link_prev[i] = NoPage;
      pg_state[i] = bba_pkg::PgNone;
      pg_level[i] = '0;
    end
    pg_state[0] = bba_pkg::PgFree;
    pg_level[0] = 4'(TopLvl);
    free_head[TopLvl] = 9'd0;
    hdr_shadow = bba_pkg::HdrReset;
  endfunction

  function automatic void list_push(int lvl, int pg);
    logic [8:0] h;
    h = free_head[lvl];
    link_next[pg] = h;
    link_prev[pg] = NoPage;
    if (h < NoPage) link_prev[h] = 9'(pg);
    free_head[lvl] = 9'(pg);
  endfunction

  function automatic void list_unlink(int lvl, int pg);
    logic [8:0] pr;
    logic [8:0] nx;
    pr = link_prev[pg];
    nx = link_next[pg];
    if (pr < NoPage) link_next[pr] = nx;
    else free_head[lvl] = nx;
    if (nx < NoPage) link_prev[nx] = pr;
    link_next[pg] = NoPage;
    link_prev[pg] = NoPage;
  endfunction

  function automatic bba_pkg::rsp_t buddy_predict(bba_pkg::req_t r);
    bba_pkg::rsp_t o;
    longint unsigned total;
    longint unsigned off;
    int order;
    int want_lvl;
    int cur;
    int pg;
    int lvl;
    int bud;
    o = '0;
    if (r.kind == 1'b0) begin
      if (r.request_size == '0) begin
        o.status = bba_pkg::ST_ZERO;
        return o;
      end
      total = ((longint'(r.request_size) + 3) & ~longint'(3)) + hdr_shadow;
      order = 12;
      while (order <= 20 && (longint'(1) << order) < total) order++;
      if (order > 20) begin
        o.status = bba_pkg::ST_OOM;
        return o;
      end
      want_lvl = order - 12;
      cur = want_lvl;
      while (cur <= TopLvl && free_head[cur] >= NoPage) cur++;
      if (cur > TopLvl) begin
        o.status = bba_pkg::ST_OOM;
        return o;
      end
      pg = free_head[cur];
      list_unlink(cur, pg);
      while (cur > want_lvl) begin
        cur--;
        bud = pg + (1 << cur);
        pg_state[bud] = bba_pkg::PgFree;
        pg_level[bud] = 4'(cur);
        list_push(cur, bud);
      end
      pg_state[pg] = bba_pkg::PgAlloc;
      pg_level[pg] = 4'(want_lvl);
      o.status = bba_pkg::ST_OK;
      o.address_res = bba_pkg::AddrW'((longint'(pg) << 12) + hdr_shadow);
      return o;
    end
    if (r.address < hdr_shadow) begin
      o.status = bba_pkg::ST_BADFREE;
      return o;
    end
    off = r.address - hdr_shadow;
    if (off[11:0] != 12'd0 || (off >> 12) >= NPages) begin
      o.status = bba_pkg::ST_BADFREE;
      return o;
    end
    pg = int'(off >> 12);
    if (pg_state[pg] != bba_pkg::PgAlloc) begin
      o.status = bba_pkg::ST_BADFREE;
      return o;
    end
    lvl = pg_level[pg];
    if (lvl > TopLvl) lvl = TopLvl;
    while (lvl < TopLvl) begin
      bud = pg ^ (1 << lvl);
      if (pg_state[bud] != bba_pkg::PgFree || pg_level[bud] != lvl) break;
      list_unlink(lvl, bud);
      if (bud < pg) begin
        pg_state[pg] = bba_pkg::PgNone;
        pg_level[pg] = '0;
        pg = bud;
      end else begin
        pg_state[bud] = bba_pkg::PgNone;
        pg_level[bud] = '0;
      end
      lvl++;
    end
    pg_state[pg] = bba_pkg::PgFree;
    pg_level[pg] = 4'(lvl);
    list_push(lvl, pg);
    o.status = bba_pkg::ST_OK;
    return o;
  endfunction

  // Present one item and hold it until the transfer; start stays high afterwards.
  task automatic issue_item(bba_pkg::req_t r, bit fixed, bba_pkg::rsp_t fixed_rsp);
    bba_pkg::rsp_t p;
    if (!quiet && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    p = buddy_predict(r);
    pending_rsp.push_back(fixed ? fixed_rsp : p);
    n_items++;
    if (r.kind == 1'b0 && p.status == bba_pkg::ST_OK) live_addr.push_back(p.address_res);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_header(logic [bba_pkg::HdrW-1:0] v);
    drain();
    if ($urandom_range(0, 99) < 8) repeat ($urandom_range(1, 6)) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready);
    hdr_shadow = v;
    cfg_valid <= 1'b0;
  endtask

  // Results: status and address compared against the oldest expectation
  always @(posedge clk_i) begin
    bba_pkg::rsp_t e;
    if (rst_ni && done_o) begin
      n_results++;
      if (pending_rsp.size() == 0) begin
        $error("unexpected result status=%0d address_res=%0h", rsp_o.status,
               rsp_o.address_res);
        n_errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_o.status != e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp_o.status);
          n_errors++;
        end
        if (rsp_o.address_res != e.address_res) begin
          $error("address_res: expected %0h, got %0h", e.address_res, rsp_o.address_res);
          n_errors++;
        end
        case (e.status)
          bba_pkg::ST_OK:  n_ok++;
          bba_pkg::ST_OOM: n_oom++;
          default:         n_bad++;
        endcase
      end
    end
  end

  typedef struct {
    logic             kind;
    int unsigned      sz;
    int unsigned      addr;
    bit               fixed;
    bba_pkg::status_e st;
    int unsigned      ad;
  } row_t;

  localparam int NRows = 20;
  row_t rows [NRows] = '{
    '{1'b0, 0,       0,       1, bba_pkg::ST_ZERO,    0},
    '{1'b0, 1048576, 0,       1, bba_pkg::ST_OOM,     0},
    '{1'b1, 0,       0,       1, bba_pkg::ST_BADFREE, 0},
    '{1'b1, 5,       20'hFFFFF, 1, bba_pkg::ST_BADFREE, 0},
    '{1'b0, 1,       20'hFFFFF, 1, bba_pkg::ST_OK,      32},
    '{1'b0, 4064,    0,       1, bba_pkg::ST_OK,      4128},
    '{1'b0, 4065,    0,       0, bba_pkg::ST_OK,      0},
    '{1'b0, 1048544, 0,       1, bba_pkg::ST_OOM,     0},
    '{1'b1, 0,       32,      1, bba_pkg::ST_OK,      0},
    '{1'b1, 0,       32,      1, bba_pkg::ST_BADFREE, 0},
    '{1'b1, 0,       4132,    1, bba_pkg::ST_BADFREE, 0},
    '{1'b1, 0,       4128,    1, bba_pkg::ST_OK,      0},
    '{1'b0, 3,       0,       0, bba_pkg::ST_OK,      0},
    '{1'b0, 2097151 & 1048576, 0, 1, bba_pkg::ST_OOM, 0},
    '{1'b0, 200000,  0,       0, bba_pkg::ST_OK,      0},
    '{1'b0, 500000,  0,       0, bba_pkg::ST_OK,      0},
    '{1'b1, 0,       20'h20,  0, bba_pkg::ST_OK,      0},
    '{1'b1, 0,       20'h1020, 0, bba_pkg::ST_OK,     0},
    '{1'b1, 0,       31,      1, bba_pkg::ST_BADFREE, 0},
    '{1'b1, 1048576, 20'hFF020, 1, bba_pkg::ST_BADFREE, 0}
  };

  task automatic random_items(int n);
    bba_pkg::req_t r;
    int unsigned k;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      quiet = (i >= n / 3 && i < n / 3 + 60);
      r.kind = 1'($urandom_range(0, 1));
      r.request_size = bba_pkg::SizeW'($urandom_range(0, 1048576));
      r.address = bba_pkg::AddrW'($urandom);
      k = $urandom_range(0, 99);
      if (k < 45) begin
        r.kind = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 70) r.request_size = bba_pkg::SizeW'($urandom_range(1, 6000));
        else if (pick < 90) r.request_size = bba_pkg::SizeW'($urandom_range(1, 70000));
        else if (pick < 97) r.request_size = bba_pkg::SizeW'($urandom_range(1, 1048576));
        else if (pick < 99) r.request_size = bba_pkg::SizeW'(1048576);
        else r.request_size = '0;
      end else if (k < 88 && live_addr.size() != 0) begin
        r.kind = 1'b1;
        pick = $urandom_range(0, live_addr.size() - 1);
        r.address = bba_pkg::AddrW'(live_addr[pick]);
        dead_addr.push_back(live_addr[pick]);
        live_addr.delete(pick);
      end else begin
        // noise: double free, misaligned, or arbitrary address
        r.kind = 1'b1;
        pick = $urandom_range(0, 2);
        if (pick == 0 && dead_addr.size() != 0)
          r.address = bba_pkg::AddrW'(dead_addr[$urandom_range(0, dead_addr.size() - 1)]);
        else if (pick == 1 && live_addr.size() != 0)
          r.address = bba_pkg::AddrW'(live_addr[0] + $urandom_range(1, 4095));
      end
      issue_item(r, 1'b0, '0);
    end
    quiet = 1'b0;
  endtask

  initial begin
    bba_pkg::req_t r;
    bba_pkg::rsp_t f;
    shadow_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < NRows; i++) begin
      r.kind = rows[i].kind;
      r.request_size = bba_pkg::SizeW'(rows[i].sz);
      r.address = bba_pkg::AddrW'(rows[i].addr);
      f.status = rows[i].st;
      f.address_res = bba_pkg::AddrW'(rows[i].ad);
      issue_item(r, rows[i].fixed, f);
    end
    random_items(150);
    // whole pool is only reachable with no header and nothing allocated
    while (live_addr.size() != 0) begin
      r = '0;
      r.kind = 1'b1;
      r.address = bba_pkg::AddrW'(live_addr.pop_front());
      issue_item(r, 1'b0, '0);
    end
    write_header('0);
    r = '0;
    r.request_size = bba_pkg::SizeW'(1048576);
    issue_item(r, 1'b0, '0);
    random_items(150);
    write_header(9'd256);
    random_items(150);
    write_header(9'($urandom_range(1, 255)));
    random_items(120);
    write_header(bba_pkg::HdrReset);
    random_items(60);
    drain();
    $display("items sent %0d, results %0d: ok %0d, out of memory %0d, rejected %0d",
             n_items, n_results, n_ok, n_oom, n_bad);
    $display("header settings 32, 0, 256, random; directed extremes and random churn");
    if (n_errors == 0 && pending_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
